@@ design/ppmb_pkg.sv @@
// Package for the per-pixel mode background block.
// Transaction structs, opcodes, lane control struct and bin constants.
// No dependencies.
`default_nettype none

package ppmb_pkg;

  localparam int BIN_W = 8;
  localparam int BINS  = 256;
  localparam int LANES = 3;

  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       op;
    logic [9:0] pixel_index;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_item_t;

  typedef struct packed {
    logic [9:0] out_pixel;
    logic [7:0] mode_blue;
    logic [7:0] mode_green;
    logic [7:0] mode_red;
  } out_item_t;

  // per-cycle command to one channel lane
  typedef struct packed {
    logic clr;   // write zero at {pix, bin}
    logic acc;   // read {pix, bin} for increment
    logic scan;  // read {pix, bin} for mode search, then zero it
  } lane_ctl_t;

endpackage

`default_nettype wire

@@ design/ppmb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read-before-write on a shared address. No dependencies.
`default_nettype none

module ppmb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wa,
  input  wire logic [WIDTH-1:0] wd,
  input  wire logic             re,
  input  wire logic [AW-1:0]    ra,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q <= mem[ra];
    end
  end

endmodule

`default_nettype wire

@@ design/ppmb_lane.sv @@
// One color channel lane: histogram RAM, saturating increment with
// write-to-read forwarding, and the running mode search of a readout.
// Depends on ppmb_pkg and ppmb_ram.
`default_nettype none

module ppmb_lane #(
  parameter int PW          = 10,
  parameter int DEPTH       = 262144,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ppmb_pkg::lane_ctl_t          ctl,
  input  wire logic [PW-1:0]                pix,
  input  wire logic [ppmb_pkg::BIN_W-1:0]   bin,
  output logic      [ppmb_pkg::BIN_W-1:0]   mode
);

  localparam int AW = PW + ppmb_pkg::BIN_W;

  logic [AW-1:0]           ra;
  logic                    re;
  logic                    we;
  logic [AW-1:0]           wa;
  logic [COUNT_WIDTH-1:0]  wd;
  logic [COUNT_WIDTH-1:0]  ram_q;
  logic [COUNT_WIDTH-1:0]  cnt;
  logic [COUNT_WIDTH-1:0]  cnt_inc;

  logic                    acc_pend_r, acc_pend_nxt;
  logic                    scan_pend_r, scan_pend_nxt;
  logic                    first_r;
  logic [AW-1:0]           addr_r;
  logic                    fwd_r, fwd_nxt;
  logic [COUNT_WIDTH-1:0]  fwd_d_r;
  logic [COUNT_WIDTH-1:0]  best_r;
  logic [ppmb_pkg::BIN_W-1:0] best_bin_r;

  assign ra = {pix, bin};
  assign re = ctl.acc | ctl.scan;

  ppmb_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .re  (re),
    .ra  (ra),
    .q   (ram_q)
  );

  // a write to the address read in the same cycle is not seen by the RAM read data
  assign cnt     = fwd_r ? fwd_d_r : ram_q;
  assign cnt_inc = (cnt == {COUNT_WIDTH{1'b1}}) ? cnt : cnt + COUNT_WIDTH'(1);

  always_comb begin
    we = 1'b0;
    wa = addr_r;
    wd = '0;
    if (ctl.clr) begin
      we = 1'b1;
      wa = ra;
    end else if (acc_pend_r) begin
      we = 1'b1;
      wd = cnt_inc;
    end else if (scan_pend_r) begin
      we = 1'b1;
    end
  end

  assign acc_pend_nxt  = ctl.acc;
  assign scan_pend_nxt = ctl.scan;
  assign fwd_nxt       = re && we && (wa == ra);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_pend_r  <= 1'b0;
      scan_pend_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      acc_pend_r  <= acc_pend_nxt;
      scan_pend_r <= scan_pend_nxt;
      fwd_r       <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_d_r <= wd;
    if (re) begin
      addr_r  <= ra;
      first_r <= (bin == '0);
    end
    // strict compare keeps the lowest bin on ties
    if (scan_pend_r && (first_r || cnt > best_r)) begin
      best_r     <= cnt;
      best_bin_r <= addr_r[ppmb_pkg::BIN_W-1:0];
    end
  end

  assign mode = best_bin_r;

endmodule

`default_nettype wire

@@ design/per_pixel_mode_background.sv @@
// Accumulate transactions: one per cycle, no result. Read transactions: a 256-bin scan
// in each lane's RAM, then one drain and one merge before the result; a pixel outside
// the image goes straight to the merge. No input is taken during a readout.
// After reset a clearing pass writes zero to every bin (PIXELS*256 addresses,
// 262144 by default), with in_stall high throughout.
// Top level: three channel lanes and the merging output register. Uses ppmb_pkg and ppmb_lane.
`default_nettype none

module per_pixel_mode_background #(
  parameter int PIXELS      = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ppmb_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ppmb_pkg::out_item_t      out_data
);

  localparam int PW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int BW    = ppmb_pkg::BIN_W;
  localparam int AW    = PW + BW;
  localparam int DEPTH = PIXELS * ppmb_pkg::BINS;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FIN   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [BW-1:0]          bin_r, bin_nxt;
  logic [PW-1:0]          pix_r;
  logic [9:0]             opix_r;
  logic                   zero_r;
  logic                   out_valid_r, out_valid_nxt;
  ppmb_pkg::out_item_t    out_r;

  logic                   in_acc;
  logic                   pix_ok;
  logic                   out_free;
  logic                   out_load;
  ppmb_pkg::lane_ctl_t    ctl;
  logic [PW-1:0]          lane_pix;
  logic [ppmb_pkg::LANES-1:0][BW-1:0] lane_bin;
  logic [ppmb_pkg::LANES-1:0][BW-1:0] lane_mode;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pix_ok   = (32'(in_data.pixel_index) < PIXELS);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_OUT) && out_free;

  // lane commands
  always_comb begin
    ctl      = '0;
    lane_pix = PW'(in_data.pixel_index);
    lane_bin = {in_data.red, in_data.green, in_data.blue};
    case (state_r)
      ST_CLEAR: begin
        ctl.clr  = 1'b1;
        lane_pix = clr_r[AW-1:BW];
        lane_bin = {3{clr_r[BW-1:0]}};
      end
      ST_IDLE: begin
        ctl.acc = in_acc && (in_data.op == ppmb_pkg::OP_ACC) && pix_ok;
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        lane_pix = pix_r;
        lane_bin = {3{bin_r}};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    bin_nxt   = bin_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && in_data.op == ppmb_pkg::OP_READ) begin
          bin_nxt   = '0;
          state_nxt = pix_ok ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        bin_nxt = bin_r + BW'(1);
        if (bin_r == ppmb_pkg::BIN_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      bin_r       <= bin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.op == ppmb_pkg::OP_READ) begin
      pix_r  <= PW'(in_data.pixel_index);
      opix_r <= in_data.pixel_index;
      zero_r <= !pix_ok;
    end
    // merge the lane results into one transaction
    if (out_load) begin
      out_r.out_pixel  <= opix_r;
      out_r.mode_blue  <= zero_r ? '0 : lane_mode[0];
      out_r.mode_green <= zero_r ? '0 : lane_mode[1];
      out_r.mode_red   <= zero_r ? '0 : lane_mode[2];
    end
  end

  for (genvar c = 0; c < ppmb_pkg::LANES; c++) begin : g_lane
    ppmb_lane #(
      .PW          (PW),
      .DEPTH       (DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .pix   (lane_pix),
      .bin   (lane_bin[c]),
      .mode  (lane_mode[c])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_read_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op == ppmb_pkg::OP_READ && pix_ok)
      |=> (state_r == ST_SCAN && bin_r == '0))
    else $error("in-range read did not start a scan at bin 0");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && bin_r == ppmb_pkg::BIN_LAST) |=> (state_r == ST_FIN))
    else $error("scan did not finish after the last bin");

  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (state_r == ST_OUT))
    else $error("drain cycle not followed by merge");

  a_merge_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == ST_IDLE))
    else $error("merged result not presented");

endmodule

`default_nettype wire

@@ dv/per_pixel_mode_background_tb.sv @@
// Self-checking testbench for per_pixel_mode_background: directed and random
// accumulate/read transactions against a histogram predictor, random stalls.
// Depends on ppmb_pkg and the per_pixel_mode_background RTL.
module per_pixel_mode_background_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXELS     = 1024;
  localparam int COUNT_W    = 8;
  localparam int RAND_ITEMS = 660;
  localparam int TAIL_WAIT  = 300;
  localparam int DRAIN_MAX  = 100000;
  localparam int HOLD_LEN   = 4000;
  localparam int STALL_MAX  = 12;
  localparam bit [COUNT_W-1:0] COUNT_TOP = '1;

  typedef struct {
    ppmb_pkg::in_item_t item;
    int unsigned        gap;
  } feed_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ppmb_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ppmb_pkg::out_item_t out_data;

  // predictor state: one count per pixel, channel and bin
  bit [COUNT_W-1:0]    tally [PIXELS][ppmb_pkg::LANES][ppmb_pkg::BINS];
  ppmb_pkg::out_item_t background_q[$];
  feed_t               stim_q[$];

  int unsigned err_cnt = 0;
  int unsigned gap_cnt = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_top = STALL_MAX;
  int unsigned long_hold = 0;
  int unsigned hold_cnt = 0;
  int unsigned results_seen = 0;

  per_pixel_mode_background #(
    .PIXELS(PIXELS),
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  task automatic note_error(string msg);
    if (err_cnt < 100) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [7:0] lane_mode(int unsigned px, int unsigned ch);
    int unsigned      best_bin;
    bit [COUNT_W-1:0] best;
    best_bin = 0;
    best = tally[px][ch][0];
    // strict compare keeps the lowest bin on ties
    for (int b = 1; b < ppmb_pkg::BINS; b++) begin
      if (tally[px][ch][b] > best) begin
        best = tally[px][ch][b];
        best_bin = b;
      end
    end
    return best_bin[7:0];
  endfunction

  function automatic void update_histograms(ppmb_pkg::in_item_t it);
    ppmb_pkg::out_item_t res;
    logic [7:0]          smp [ppmb_pkg::LANES];
    smp[0] = it.blue;
    smp[1] = it.green;
    smp[2] = it.red;
    if (it.op == ppmb_pkg::OP_ACC) begin
      if (it.pixel_index < PIXELS) begin
        for (int c = 0; c < ppmb_pkg::LANES; c++) begin
          if (tally[it.pixel_index][c][smp[c]] != COUNT_TOP)
            tally[it.pixel_index][c][smp[c]]++;
        end
      end
    end else begin
      res = '0;
      res.out_pixel = it.pixel_index;
      if (it.pixel_index < PIXELS) begin
        res.mode_blue  = lane_mode(it.pixel_index, 0);
        res.mode_green = lane_mode(it.pixel_index, 1);
        res.mode_red   = lane_mode(it.pixel_index, 2);
        for (int c = 0; c < ppmb_pkg::LANES; c++)
          for (int b = 0; b < ppmb_pkg::BINS; b++)
            tally[it.pixel_index][c][b] = '0;
      end
      background_q.insert(background_q.size(), res);
    end
  endfunction

  task automatic compare_background(ppmb_pkg::out_item_t got);
    ppmb_pkg::out_item_t want;
    if (background_q.size() == 0) begin
      note_error($sformatf("unexpected result for pixel %0d", got.out_pixel));
      return;
    end
    want = background_q.pop_front();
    if (got.out_pixel != want.out_pixel)
      note_error($sformatf("out_pixel: expected %0d, got %0d", want.out_pixel, got.out_pixel));
    if (got.mode_blue != want.mode_blue)
      note_error($sformatf("pixel %0d mode_blue: expected %0d, got %0d",
                           want.out_pixel, want.mode_blue, got.mode_blue));
    if (got.mode_green != want.mode_green)
      note_error($sformatf("pixel %0d mode_green: expected %0d, got %0d",
                           want.out_pixel, want.mode_green, got.mode_green));
    if (got.mode_red != want.mode_red)
      note_error($sformatf("pixel %0d mode_red: expected %0d, got %0d",
                           want.out_pixel, want.mode_red, got.mode_red));
  endtask

  function automatic void queue_item(logic op, int unsigned px, int unsigned b,
                                     int unsigned g, int unsigned r, int unsigned gap);
    feed_t f;
    f.item.op          = op;
    f.item.pixel_index = 10'(px);
    f.item.blue        = 8'(b);
    f.item.green       = 8'(g);
    f.item.red         = 8'(r);
    f.gap              = gap;
    stim_q.insert(stim_q.size(), f);
  endfunction

  // driver: next transaction goes out once its idle gap has elapsed
  always @(posedge clk) begin : drive
    logic take;
    take = in_valid && !in_stall;
    if (take) update_histograms(in_data);
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt <= 0;
    end else if (!in_valid || take) begin
      if (stim_q.size() != 0 && gap_cnt >= stim_q[0].gap) begin
        in_data <= stim_q[0].item;
        in_valid <= 1'b1;
        void'(stim_q.pop_front());
        gap_cnt <= 0;
      end else begin
        in_valid <= 1'b0;
        if (stim_q.size() != 0) gap_cnt <= gap_cnt + 1;
      end
    end
  end

  // long hold-off: after the twelfth result the receiver stalls while long_hold, loaded with HOLD_LEN, runs down
  always @(posedge clk) begin : hold_off
    if (!rst_n) begin
      long_hold <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) hold_cnt <= hold_cnt + 1;
      if (long_hold != 0) long_hold <= long_hold - 1;
      else if (out_valid && !out_stall && hold_cnt == 11) long_hold <= HOLD_LEN;
    end
  end

  // monitor: random stall per result
  always @(posedge clk) begin : watch
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        compare_background(out_data);
        results_seen++;
        if (results_seen % 16 == 0) rx_top = ($urandom_range(0, 2) == 0) ? 0 : STALL_MAX;
        rx_wait = $urandom_range(0, rx_top);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0) || (long_hold != 0);
    end
  end

  initial begin : run
    int unsigned made, gap_top, seq_len, px, spin;
    logic [7:0]  pal [ppmb_pkg::LANES][3];
    logic [7:0]  smp [ppmb_pkg::LANES];

    // empty histograms read as bin 0; read fields other than pixel are don't-care
    queue_item(ppmb_pkg::OP_READ, 0, 0, 0, 0, $urandom_range(0, STALL_MAX));
    queue_item(ppmb_pkg::OP_READ, PIXELS - 1, 255, 255, 255, $urandom_range(0, STALL_MAX));
    // equal counts at both extremes: lowest bin wins
    queue_item(ppmb_pkg::OP_ACC, PIXELS - 1, 255, 255, 255, 0);
    queue_item(ppmb_pkg::OP_ACC, PIXELS - 1, 255, 255, 255, $urandom_range(0, STALL_MAX));
    queue_item(ppmb_pkg::OP_ACC, PIXELS - 1, 0, 0, 0, 0);
    queue_item(ppmb_pkg::OP_ACC, PIXELS - 1, 0, 0, 0, $urandom_range(0, STALL_MAX));
    queue_item(ppmb_pkg::OP_READ, PIXELS - 1, 0, 0, 0, 0);
    queue_item(ppmb_pkg::OP_READ, PIXELS - 1, 0, 0, 0, 0);
    queue_item(ppmb_pkg::OP_ACC, 0, 255, 0, 128, $urandom_range(0, STALL_MAX));
    queue_item(ppmb_pkg::OP_READ, 0, 85, 170, 255, 0);
    // mid-range tie and a clear winner in the other lanes
    queue_item(ppmb_pkg::OP_ACC, 512, 9, 100, 33, 0);
    queue_item(ppmb_pkg::OP_ACC, 512, 7, 100, 34, 0);
    queue_item(ppmb_pkg::OP_ACC, 512, 9, 101, 34, $urandom_range(0, STALL_MAX));
    queue_item(ppmb_pkg::OP_ACC, 512, 7, 100, 35, 0);
    queue_item(ppmb_pkg::OP_READ, 512, 255, 255, 255, $urandom_range(0, STALL_MAX));
    queue_item(ppmb_pkg::OP_ACC, 682, 170, 85, 254, 0);
    queue_item(ppmb_pkg::OP_READ, 682, 0, 0, 0, 0);

    // bin 10 saturates; wrapping counts would let the five bin-200 samples win
    for (int i = 0; i < (1 << COUNT_W) + 4; i++)
      queue_item(ppmb_pkg::OP_ACC, 341, 10, 20, 30, 0);
    for (int i = 0; i < 5; i++) queue_item(ppmb_pkg::OP_ACC, 341, 200, 20, 5, 0);
    queue_item(ppmb_pkg::OP_READ, 341, 0, 0, 0, 0);
    queue_item(ppmb_pkg::OP_READ, 341, 0, 0, 0, 0);

    // random: per-pixel runs drawn from a small palette, mostly followed by a read
    made = 0;
    while (made < RAND_ITEMS) begin
      gap_top = ($urandom_range(0, 9) < 3) ? 0 : STALL_MAX;
      px = $urandom_range(0, PIXELS - 1);
      for (int c = 0; c < ppmb_pkg::LANES; c++)
        for (int k = 0; k < 3; k++) pal[c][k] = $urandom_range(0, 255);
      seq_len = $urandom_range(1, 20);
      for (int i = 0; i < seq_len; i++) begin
        for (int c = 0; c < ppmb_pkg::LANES; c++)
          smp[c] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                               : pal[c][$urandom_range(0, 2)];
        if ($urandom_range(0, 9) == 0)
          queue_item(ppmb_pkg::OP_ACC, $urandom_range(0, PIXELS - 1), smp[0], smp[1],
                     smp[2], $urandom_range(0, gap_top));
        else
          queue_item(ppmb_pkg::OP_ACC, px, smp[0], smp[1], smp[2],
                     $urandom_range(0, gap_top));
      end
      made += seq_len;
      if ($urandom_range(0, 9) != 0) begin
        queue_item(ppmb_pkg::OP_READ, px, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, gap_top));
        made++;
      end
      if ($urandom_range(0, 14) == 0) begin
        queue_item(ppmb_pkg::OP_READ, $urandom_range(0, PIXELS - 1), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, gap_top));
        made++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    spin = 0;
    while (background_q.size() != 0 && spin < DRAIN_MAX) begin
      @(posedge clk);
      spin++;
    end
    repeat (TAIL_WAIT) @(posedge clk);
    if (background_q.size() != 0)
      note_error($sformatf("%0d expected results never arrived", background_q.size()));

    if (err_cnt == 0) $display("per_pixel_mode_background_tb: clean");
    else $display("per_pixel_mode_background_tb: errors");
    $finish;
  end

  // covers the post-reset clearing pass, the saturation burst and all readouts
  initial begin : watchdog
    #(25_000_000);
    $display("per_pixel_mode_background_tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
design/ppmb_pkg.sv
design/ppmb_ram.sv
design/ppmb_lane.sv
design/per_pixel_mode_background.sv
dv/per_pixel_mode_background_tb.sv
